/* design/amh_pkg.sv */
// Package for the addressable max-heap: field widths, operation and status codes.
`default_nettype none
package amh_pkg;
	localparam int CAPACITY_DEF     = 64;
	localparam int HANDLE_COUNT_DEF = 64;
	localparam int KIND_W   = 3;
	localparam int HANDLE_W = 6;
	localparam int PRIO_W   = 64;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef logic [KIND_W-1:0]   kind_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam kind_t KIND_INSERT     = 3'd0;
	localparam kind_t KIND_REMOVE     = 3'd1;
	localparam kind_t KIND_CHANGE     = 3'd2;
	localparam kind_t KIND_RAW_INSERT = 3'd3;
	localparam kind_t KIND_RAW_REMOVE = 3'd4;
	localparam kind_t KIND_REBUILD    = 3'd5;
	localparam kind_t KIND_CLEAR      = 3'd6;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_FULL    = 2'd1;
	localparam status_t ST_ABSENT  = 2'd2;
	localparam status_t ST_PRESENT = 2'd3;
endpackage
`default_nettype wire

/* design/addressable_max_heap.sv */
// Top level of the addressable max-heap with its slot memory and sift sequencer.
`default_nettype none
// Addressable binary max-heap. One 80-bit transaction in (kind, handle, priority_req) gives
// one 80-bit result out (status, count, is_empty, top_handle, top_priority). Slot contents
// and the handle-to-slot table live in two memories, each with one registered read and one
// write per cycle. One 64-bit comparator walks the tree under a small sequencer. The entry
// being sifted stays in registers and is written to its final slot only once. While an
// operation runs, s_axis_tready is low. The steps from acceptance to m_axis_tvalid:
// - a rejected transaction or the unused kind is decoded, then the top entry is read;
// - a raw insert writes the new entry straight into the new tail slot;
// - a raw remove moves the tail entry into the hole, or moves nothing when it removes
//   the last slot;
// - an insert sifts up from the new tail slot, comparing one parent per level;
// - a change or remove first tries to sift up and else sifts down, reading the left and
//   then the right child at each level where it exists; removing the last slot sifts nothing;
// - a rebuild runs one sift down for each of the count/2 inner slots;
// - a clear walks the handle table one entry a cycle.
// After reset the same walk runs once, and the block takes no transaction until it ends.
// The result is held in an output register until it is accepted. The next transaction
// can be taken in the cycle after that.
module addressable_max_heap #(
	parameter int CAPACITY     = amh_pkg::CAPACITY_DEF,
	parameter int HANDLE_COUNT = amh_pkg::HANDLE_COUNT_DEF
) (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        s_axis_tvalid,
	output logic              s_axis_tready,
	// [2:0] kind, [8:3] handle, [72:9] priority_req, [79:73] zero
	input  wire  logic [79:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire  logic        m_axis_tready,
	// [1:0] status, [8:2] count, [9] is_empty, [15:10] top_handle,
	// [79:16] top_priority
	output logic [79:0]       m_axis_tdata
);
	import amh_pkg::*;

	localparam int SW = $clog2(CAPACITY + 1);   // slot index, holds CAPACITY
	localparam int HW = $clog2(HANDLE_COUNT);

	localparam logic [3:0] S_INIT  = 4'd0,  S_IDLE  = 4'd1,  S_DEC   = 4'd2,
	                       S_TAIL  = 4'd3,  S_UPRD  = 4'd4,  S_UPCMP = 4'd5,
	                       S_DNST  = 4'd6,  S_DNL   = 4'd7,  S_DNR   = 4'd8,
	                       S_DNMV  = 4'd9,  S_PUT   = 4'd10, S_RBLD  = 4'd11,
	                       S_RBLE  = 4'd12, S_TOPR  = 4'd13, S_TOPW  = 4'd14;

	// slot memory (slot 0 unused) and handle table
	logic [HANDLE_W-1:0] mem_h [CAPACITY+1];
	logic [PRIO_W-1:0]   mem_p [CAPACITY+1];
	logic [SW-1:0]       hslot [HANDLE_COUNT];

	logic [3:0]          state_q;
	kind_t               kind_q;
	logic [HANDLE_W-1:0] eh_q, bh_q;
	logic [PRIO_W-1:0]   ep_q, bp_q;
	logic                hvalid_q, sift_q, moved_q, clr_op_q;
	logic [SW-1:0]       cnt_q, cur_q, bs_q, rb_q;
	logic [HW-1:0]       clr_q;
	status_t             status_q;
	logic [79:0]         out_q;
	logic                ovalid_q;

	// slot memory port
	logic [SW-1:0]       sm_ra, sm_wa;
	logic                sm_we;
	logic [HANDLE_W-1:0] sm_wh, sm_rh_q;
	logic [PRIO_W-1:0]   sm_wp, sm_rp_q;
	// handle table port
	logic [HW-1:0]       ht_ra, ht_wa;
	logic                ht_we;
	logic [SW-1:0]       ht_wd, ht_rd_q;
	// shared comparator: a > b
	logic [PRIO_W-1:0]   cmp_a, cmp_b;
	logic                cmp_gt;

	logic [SW:0]         lft, rgt, cnt_x;
	logic                held;

	assign cmp_gt = cmp_a > cmp_b;
	assign lft    = {cur_q, 1'b0};
	assign rgt    = {cur_q, 1'b1};
	assign cnt_x  = {1'b0, cnt_q};
	// handle table read was taken at the accepting edge
	assign held   = hvalid_q && (ht_rd_q != '0);

	assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = out_q;

	always_ff @(posedge clk) begin
		if (sm_we) begin
			mem_h[sm_wa] <= sm_wh;
			mem_p[sm_wa] <= sm_wp;
		end
		sm_rh_q <= mem_h[sm_ra];
		sm_rp_q <= mem_p[sm_ra];
	end

	always_ff @(posedge clk) begin
		if (ht_we) begin
			hslot[ht_wa] <= ht_wd;
		end
		ht_rd_q <= hslot[ht_ra];
	end

	// memory addresses, write ports and comparator operands per state
	always_comb begin
		sm_ra = cur_q;
		sm_we = 1'b0;
		sm_wa = cur_q;
		sm_wh = eh_q;
		sm_wp = ep_q;
		ht_ra = HW'(s_axis_tdata[8:3]);
		ht_we = 1'b0;
		ht_wa = HW'(eh_q);
		ht_wd = cur_q;
		cmp_a = ep_q;
		cmp_b = sm_rp_q;
		unique case (state_q)
			S_INIT: begin
				ht_we = 1'b1;
				ht_wa = clr_q;
				ht_wd = '0;
			end
			S_DEC: begin
				// fetch the tail entry and drop the removed handle
				sm_ra = cnt_q;
				ht_we = held && ((kind_q == KIND_REMOVE) || (kind_q == KIND_RAW_REMOVE));
				ht_wd = '0;
			end
			S_UPRD: sm_ra = cur_q >> 1;
			S_UPCMP: begin
				// parent moves down into the hole when the entry beats it
				sm_we = cmp_gt;
				sm_wh = sm_rh_q;
				sm_wp = sm_rp_q;
				ht_we = cmp_gt;
				ht_wa = HW'(sm_rh_q);
			end
			S_DNST: sm_ra = lft[SW-1:0];
			S_DNL: begin
				cmp_a = sm_rp_q;
				cmp_b = ep_q;
				sm_ra = rgt[SW-1:0];
			end
			S_DNR: begin
				cmp_a = sm_rp_q;
				cmp_b = bp_q;
			end
			S_DNMV: begin
				// larger child rises into the hole
				sm_we = (bs_q != cur_q);
				sm_wh = bh_q;
				sm_wp = bp_q;
				ht_we = (bs_q != cur_q);
				ht_wa = HW'(bh_q);
			end
			S_PUT: begin
				sm_we = 1'b1;
				ht_we = 1'b1;
			end
			S_RBLD: sm_ra = rb_q;
			S_TOPR: sm_ra = SW'(1);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			kind_q   <= KIND_INSERT;
			eh_q     <= '0;
			ep_q     <= '0;
			bh_q     <= '0;
			bp_q     <= '0;
			bs_q     <= '0;
			hvalid_q <= 1'b0;
			sift_q   <= 1'b0;
			moved_q  <= 1'b0;
			clr_op_q <= 1'b0;
			cnt_q    <= '0;
			cur_q    <= '0;
			rb_q     <= '0;
			clr_q    <= '0;
			status_q <= ST_OK;
			out_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == S_TOPW) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					// walk the handle table clearing one entry a cycle
					clr_q <= clr_q + 1'b1;
					if (clr_q == HW'(HANDLE_COUNT - 1)) begin
						state_q <= clr_op_q ? S_TOPR : S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						kind_q   <= s_axis_tdata[2:0];
						eh_q     <= s_axis_tdata[8:3];
						ep_q     <= s_axis_tdata[72:9];
						hvalid_q <= 32'(s_axis_tdata[8:3]) < HANDLE_COUNT;
						status_q <= ST_OK;
						moved_q  <= 1'b0;
						state_q  <= S_DEC;
					end
				end
				S_DEC: begin
					unique case (kind_q)
						KIND_INSERT, KIND_RAW_INSERT: begin
							if (!hvalid_q) begin
								status_q <= ST_ABSENT;
								state_q  <= S_TOPR;
							end else if (held) begin
								status_q <= ST_PRESENT;
								state_q  <= S_TOPR;
							end else if (32'(cnt_q) >= CAPACITY) begin
								status_q <= ST_FULL;
								state_q  <= S_TOPR;
							end else begin
								cnt_q   <= cnt_q + 1'b1;
								cur_q   <= cnt_q + 1'b1;
								state_q <= (kind_q == KIND_INSERT) ? S_UPRD : S_PUT;
							end
						end
						KIND_REMOVE, KIND_RAW_REMOVE: begin
							if (!held) begin
								status_q <= ST_ABSENT;
								state_q  <= S_TOPR;
							end else begin
								// tail entry fills the hole unless the hole is the tail
								cnt_q   <= cnt_q - 1'b1;
								cur_q   <= ht_rd_q;
								sift_q  <= (kind_q == KIND_REMOVE);
								state_q <= (ht_rd_q < cnt_q) ? S_TAIL : S_TOPR;
							end
						end
						KIND_CHANGE: begin
							if (!held) begin
								status_q <= ST_ABSENT;
								state_q  <= S_TOPR;
							end else begin
								cur_q   <= ht_rd_q;
								state_q <= S_UPRD;
							end
						end
						KIND_REBUILD: begin
							rb_q    <= cnt_q >> 1;
							state_q <= S_RBLD;
						end
						KIND_CLEAR: begin
							cnt_q    <= '0;
							clr_q    <= '0;
							clr_op_q <= 1'b1;
							state_q  <= S_INIT;
						end
						default: state_q <= S_TOPR;
					endcase
				end
				S_TAIL: begin
					eh_q    <= sm_rh_q;
					ep_q    <= sm_rp_q;
					state_q <= sift_q ? S_UPRD : S_PUT;
				end
				S_UPRD: begin
					if (cur_q == SW'(1)) begin
						state_q <= moved_q ? S_PUT : S_DNST;
					end else begin
						state_q <= S_UPCMP;
					end
				end
				S_UPCMP: begin
					// stop when the parent is at least the entry
					if (cmp_gt) begin
						cur_q   <= cur_q >> 1;
						moved_q <= 1'b1;
						state_q <= S_UPRD;
					end else begin
						state_q <= moved_q ? S_PUT : S_DNST;
					end
				end
				S_DNST: state_q <= (lft > cnt_x) ? S_PUT : S_DNL;
				S_DNL: begin
					// left child wins only when strictly larger
					if (cmp_gt) begin
						bs_q <= lft[SW-1:0];
						bh_q <= sm_rh_q;
						bp_q <= sm_rp_q;
					end else begin
						bs_q <= cur_q;
						bh_q <= eh_q;
						bp_q <= ep_q;
					end
					state_q <= (rgt > cnt_x) ? S_DNMV : S_DNR;
				end
				S_DNR: begin
					if (cmp_gt) begin
						bs_q <= rgt[SW-1:0];
						bh_q <= sm_rh_q;
						bp_q <= sm_rp_q;
					end
					state_q <= S_DNMV;
				end
				S_DNMV: begin
					if (bs_q == cur_q) begin
						state_q <= S_PUT;
					end else begin
						cur_q   <= bs_q;
						state_q <= S_DNST;
					end
				end
				S_PUT: state_q <= (kind_q == KIND_REBUILD) ? S_RBLD : S_TOPR;
				S_RBLD: begin
					if (rb_q == '0) begin
						state_q <= S_TOPR;
					end else begin
						cur_q   <= rb_q;
						rb_q    <= rb_q - 1'b1;
						state_q <= S_RBLE;
					end
				end
				S_RBLE: begin
					eh_q    <= sm_rh_q;
					ep_q    <= sm_rp_q;
					state_q <= S_DNST;
				end
				S_TOPR: state_q <= S_TOPW;
				S_TOPW: begin
					out_q[1:0]   <= status_q;
					out_q[8:2]   <= COUNT_W'(cnt_q);
					out_q[9]     <= (cnt_q == '0);
					out_q[15:10] <= (cnt_q == '0) ? '0 : sm_rh_q;
					out_q[79:16] <= (cnt_q == '0) ? '0 : sm_rp_q;
					clr_op_q     <= 1'b0;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// no overlap between accepting and an undelivered result
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid) else $error("ready with pending result");
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= CAPACITY) else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[9] == (m_axis_tdata[8:2] == '0)))
		else $error("is_empty mismatch");
	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
endmodule
`default_nettype wire

/* test/addressable_max_heap_tb.sv */
// Testbench for the addressable max-heap: predicts and checks every result transaction.
`timescale 1ns / 1ps
module addressable_max_heap_tb;
	import amh_pkg::*;

	localparam int CAP     = CAPACITY_DEF;
	localparam int HCOUNT  = HANDLE_COUNT_DEF;
	localparam int WD_LIMIT = 20000;

	typedef struct packed {
		logic [63:0] prio;
		logic [5:0]  handle;
		kind_t       kind;
	} heap_op_t;

	typedef struct packed {
		logic [63:0] top_prio;
		logic [5:0]  top_handle;
		logic        is_empty;
		logic [6:0]  count;
		status_t     status;
	} heap_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;

	addressable_max_heap u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// shadow heap
	logic [5:0]  sh_handle [1:CAP];
	logic [63:0] sh_prio [1:CAP];
	int          sh_slot [HCOUNT];
	int          sh_count;

	heap_op_t  pending_ops[$];
	heap_res_t expected_results[$];
	int        errors = 0;
	int        send_idle_pct = 31, recv_idle_pct = 84;
	bit        hold_send = 0;
	bit        stim_done = 0;

	function automatic void put_slot(int s, logic [5:0] h, logic [63:0] p);
		sh_handle[s] = h;
		sh_prio[s] = p;
		sh_slot[h] = s;
	endfunction

	function automatic void swap_slots(int a, int b);
		logic [5:0]  h;
		logic [63:0] p;
		h = sh_handle[a];
		p = sh_prio[a];
		put_slot(a, sh_handle[b], sh_prio[b]);
		put_slot(b, h, p);
	endfunction

	function automatic bit bubble_up(int s);
		bit moved;
		moved = 0;
		while (s > 1 && sh_prio[s/2] < sh_prio[s]) begin
			swap_slots(s/2, s);
			moved = 1;
			s = s / 2;
		end
		return moved;
	endfunction

	function automatic void push_down(int s);
		int best;
		while (2*s <= sh_count) begin
			best = s;
			if (sh_prio[2*s] > sh_prio[best]) best = 2*s;
			if (2*s+1 <= sh_count && sh_prio[2*s+1] > sh_prio[best]) best = 2*s+1;
			if (best == s) break;
			swap_slots(best, s);
			s = best;
		end
	endfunction

	// Apply one operation to the shadow heap and return its result.
	function automatic heap_res_t apply_heap_op(heap_op_t op);
		heap_res_t r;
		int s;
		bit held;
		r = '0;
		r.status = ST_OK;
		held = sh_slot[op.handle] != 0;
		case (op.kind)
			KIND_INSERT, KIND_RAW_INSERT: begin
				if (held) r.status = ST_PRESENT;
				else if (sh_count >= CAP) r.status = ST_FULL;
				else begin
					sh_count++;
					put_slot(sh_count, op.handle, op.prio);
					if (op.kind == KIND_INSERT) void'(bubble_up(sh_count));
				end
			end
			KIND_REMOVE, KIND_RAW_REMOVE: begin
				if (!held) r.status = ST_ABSENT;
				else begin
					s = sh_slot[op.handle];
					sh_slot[op.handle] = 0;
					if (s < sh_count) put_slot(s, sh_handle[sh_count], sh_prio[sh_count]);
					sh_count--;
					if (op.kind == KIND_REMOVE && s <= sh_count)
						if (!bubble_up(s)) push_down(s);
				end
			end
			KIND_CHANGE: begin
				if (!held) r.status = ST_ABSENT;
				else begin
					s = sh_slot[op.handle];
					sh_prio[s] = op.prio;
					if (!bubble_up(s)) push_down(s);
				end
			end
			KIND_REBUILD: for (s = sh_count / 2; s >= 1; s--) push_down(s);
			KIND_CLEAR: begin
				sh_count = 0;
				foreach (sh_slot[i]) sh_slot[i] = 0;
			end
			default: ;
		endcase
		r.count = sh_count[6:0];
		r.is_empty = sh_count == 0;
		if (sh_count != 0) begin
			r.top_handle = sh_handle[1];
			r.top_prio = sh_prio[1];
		end
		return r;
	endfunction

	function automatic logic [63:0] rand_prio();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 64'($urandom_range(0, 7));
			3: return {$urandom(), $urandom()} | 64'h8000_0000_0000_0000;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function automatic heap_op_t make_op(kind_t k, int h, logic [63:0] p);
		heap_op_t op;
		op.kind = k;
		op.handle = h[5:0];
		op.prio = p;
		return op;
	endfunction

	// Driver: advance the pending queue one transaction at a time.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_ops.size() != 0 && !hold_send &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {7'd0, pending_ops.pop_front()};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Predict at acceptance, so the shadow sees operations in block order.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			expected_results.push_back(apply_heap_op(heap_op_t'(s_axis_tdata[72:0])));
	end

	// Monitor: stall at random and compare each result transaction.
	always @(posedge clk or negedge arst_n) begin
		heap_res_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = heap_res_t'(m_axis_tdata);
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction %h", m_axis_tdata);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						errors++;
					end
					if (got.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, got.count);
						errors++;
					end
					if (got.is_empty !== want.is_empty) begin
						$error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
						errors++;
					end
					if (got.top_handle !== want.top_handle) begin
						$error("top_handle: expected %0d, got %0d",
							want.top_handle, got.top_handle);
						errors++;
					end
					if (got.top_prio !== want.top_prio) begin
						$error("top_priority: expected %h, got %h",
							want.top_prio, got.top_prio);
						errors++;
					end
				end
			end
			m_axis_tready <= $urandom_range(0, 99) >= recv_idle_pct;
		end
	end

	// Watchdog: count cycles without any transaction.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("addressable_max_heap_tb: done, errors");
			$finish;
		end
	end

	// Random traffic: mostly inserts/removes/changes over all 64 handles.
	task automatic queue_random(int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 35)
				pending_ops.push_back(make_op(KIND_INSERT, $urandom_range(0, 63), rand_prio()));
			else if (k < 52)
				pending_ops.push_back(make_op(KIND_REMOVE, $urandom_range(0, 63), '0));
			else if (k < 67)
				pending_ops.push_back(make_op(KIND_CHANGE, $urandom_range(0, 63), rand_prio()));
			else if (k < 77)
				pending_ops.push_back(make_op(KIND_RAW_INSERT, $urandom_range(0, 63),
					rand_prio()));
			else if (k < 85)
				pending_ops.push_back(make_op(KIND_RAW_REMOVE, $urandom_range(0, 63), '0));
			else if (k < 94)
				pending_ops.push_back(make_op(KIND_REBUILD, $urandom_range(0, 63), rand_prio()));
			else if (k < 97)
				pending_ops.push_back(make_op(kind_t'(3'd7), $urandom_range(0, 63),
					rand_prio()));
			else
				pending_ops.push_back(make_op(KIND_CLEAR, $urandom_range(0, 63), '0));
		end
	endtask

	task automatic drain();
		while (pending_ops.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		sh_count = 0;
		foreach (sh_slot[i]) sh_slot[i] = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty cases, extremes, duplicates, raw moves, unused kind.
		pending_ops.push_back(make_op(KIND_REMOVE, 0, '0));
		pending_ops.push_back(make_op(KIND_CHANGE, 63, '1));
		pending_ops.push_back(make_op(KIND_REBUILD, 0, '0));
		pending_ops.push_back(make_op(KIND_INSERT, 0, '0));
		pending_ops.push_back(make_op(KIND_INSERT, 63, '1));
		pending_ops.push_back(make_op(KIND_INSERT, 63, 64'd5));
		pending_ops.push_back(make_op(KIND_RAW_INSERT, 0, 64'd9));
		pending_ops.push_back(make_op(KIND_RAW_INSERT, 21, 64'hAAAA_AAAA_AAAA_AAAA));
		pending_ops.push_back(make_op(KIND_RAW_INSERT, 42, 64'h5555_5555_5555_5555));
		pending_ops.push_back(make_op(KIND_CHANGE, 0, '1));
		pending_ops.push_back(make_op(KIND_REBUILD, 0, '0));
		pending_ops.push_back(make_op(KIND_RAW_REMOVE, 63, '0));
		pending_ops.push_back(make_op(KIND_REMOVE, 21, '0));
		pending_ops.push_back(make_op(kind_t'(3'd7), 63, '1));
		pending_ops.push_back(make_op(KIND_CLEAR, 0, '0));
		pending_ops.push_back(make_op(KIND_REMOVE, 42, '0));
		// Fill to capacity, then insert handles that are already held.
		for (int h = 0; h < CAP; h++)
			pending_ops.push_back(make_op(KIND_INSERT, h, rand_prio()));
		pending_ops.push_back(make_op(KIND_INSERT, 5, '0));
		pending_ops.push_back(make_op(KIND_RAW_INSERT, 6, '0));
		pending_ops.push_back(make_op(KIND_REBUILD, 0, '0));
		pending_ops.push_back(make_op(KIND_CLEAR, 0, '0));

		queue_random(500);
		drain();
		// All results are in; pause with the sender held.
		hold_send = 1;
		repeat (20) @(posedge clk);
		hold_send = 0;
		send_idle_pct = 84;
		recv_idle_pct = 31;
		queue_random(550);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(520);
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("addressable_max_heap_tb: done, clean");
		else
			$display("addressable_max_heap_tb: done, errors");
		$finish;
	end
endmodule
